FILE: hdl/ffe_pkg.sv
// shared types and constants of the flip-flop estimator
// no dependencies; used by every other file in hdl
package ffe_pkg;

  localparam int SAMPLE_BITS   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int AVG_BITS      = SAMPLE_BITS + FRACTION_BITS;
  localparam int GAIN_BITS     = 16;
  localparam int GAIN_REG_BITS = GAIN_BITS + 1;
  localparam int FACTOR_BITS   = 20;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 32;
  localparam int INDEX_BITS    = 3;

  localparam logic [INDEX_BITS-1:0] REG_FAST_GAIN    = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_SLOW_GAIN    = 3'd1;
  localparam logic [INDEX_BITS-1:0] REG_RANGE_GAIN   = 3'd2;
  localparam logic [INDEX_BITS-1:0] REG_CENTER_GAIN  = 3'd3;
  localparam logic [INDEX_BITS-1:0] REG_LIMIT_FACTOR = 3'd4;

  localparam logic [GAIN_REG_BITS-1:0] FAST_GAIN_RESET    = 17'd6554;
  localparam logic [GAIN_REG_BITS-1:0] SLOW_GAIN_RESET    = 17'd58982;
  localparam logic [GAIN_REG_BITS-1:0] RANGE_GAIN_RESET   = 17'd58982;
  localparam logic [GAIN_REG_BITS-1:0] CENTER_GAIN_RESET  = 17'd6554;
  localparam logic [FACTOR_BITS-1:0]   LIMIT_FACTOR_RESET = 20'd174297;

  typedef struct packed {
    logic [GAIN_REG_BITS-1:0] fast_gain;
    logic [GAIN_REG_BITS-1:0] slow_gain;
    logic [GAIN_REG_BITS-1:0] range_gain;
    logic [GAIN_REG_BITS-1:0] center_gain;
    logic [FACTOR_BITS-1:0]   limit_factor;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] estimate;
    logic                   alarm;
  } result_t;

endpackage

FILE: hdl/ffe_sample_if.sv
// input channel of the flip-flop estimator: one sample beat
// depends on ffe_pkg
interface ffe_sample_if;
  logic                            valid;
  logic                            ready;
  logic [ffe_pkg::SAMPLE_BITS-1:0] sample;
  logic                            mode;

  modport source (output valid, output sample, output mode, input ready);
  modport sink (input valid, input sample, input mode, output ready);
endinterface

FILE: hdl/ffe_result_if.sv
// output channel of the flip-flop estimator: one result beat
// depends on ffe_pkg
interface ffe_result_if;
  logic                            valid;
  logic                            ready;
  logic [ffe_pkg::SAMPLE_BITS-1:0] estimate;
  logic                            alarm;

  modport source (output valid, output estimate, output alarm, input ready);
  modport sink (input valid, input estimate, input alarm, output ready);
endinterface

FILE: hdl/ffe_cfg_regs.sv
// apb register file holding the gains and the limit factor
// depends on ffe_pkg
module ffe_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffe_pkg::ADDR_BITS-1:0] paddr,
  input  logic [ffe_pkg::DATA_BITS-1:0] pwdata,
  output logic [ffe_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  output ffe_pkg::cfg_t                 cfg
);

  logic                            wr_en;
  logic [ffe_pkg::INDEX_BITS-1:0]  index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign index  = paddr[ffe_pkg::ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_gain    <= ffe_pkg::FAST_GAIN_RESET;
      cfg.slow_gain    <= ffe_pkg::SLOW_GAIN_RESET;
      cfg.range_gain   <= ffe_pkg::RANGE_GAIN_RESET;
      cfg.center_gain  <= ffe_pkg::CENTER_GAIN_RESET;
      cfg.limit_factor <= ffe_pkg::LIMIT_FACTOR_RESET;
    end else if (wr_en) begin
      unique case (index)
        ffe_pkg::REG_FAST_GAIN:    cfg.fast_gain    <= pwdata[ffe_pkg::GAIN_REG_BITS-1:0];
        ffe_pkg::REG_SLOW_GAIN:    cfg.slow_gain    <= pwdata[ffe_pkg::GAIN_REG_BITS-1:0];
        ffe_pkg::REG_RANGE_GAIN:   cfg.range_gain   <= pwdata[ffe_pkg::GAIN_REG_BITS-1:0];
        ffe_pkg::REG_CENTER_GAIN:  cfg.center_gain  <= pwdata[ffe_pkg::GAIN_REG_BITS-1:0];
        ffe_pkg::REG_LIMIT_FACTOR: cfg.limit_factor <= pwdata[ffe_pkg::FACTOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      ffe_pkg::REG_FAST_GAIN:    prdata[ffe_pkg::GAIN_REG_BITS-1:0] = cfg.fast_gain;
      ffe_pkg::REG_SLOW_GAIN:    prdata[ffe_pkg::GAIN_REG_BITS-1:0] = cfg.slow_gain;
      ffe_pkg::REG_RANGE_GAIN:   prdata[ffe_pkg::GAIN_REG_BITS-1:0] = cfg.range_gain;
      ffe_pkg::REG_CENTER_GAIN:  prdata[ffe_pkg::GAIN_REG_BITS-1:0] = cfg.center_gain;
      ffe_pkg::REG_LIMIT_FACTOR: prdata[ffe_pkg::FACTOR_BITS-1:0]   = cfg.limit_factor;
      default:                   prdata = '0;
    endcase
  end

endmodule

FILE: hdl/ffe_core.sv
// estimator state and its update: limit test, four ewmas, estimate
// depends on ffe_pkg
module ffe_core (
  input  logic                            clk,
  input  logic                            rst,
  input  ffe_pkg::cfg_t                   cfg,
  input  logic                            advance,
  input  logic [ffe_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                            mode,
  output ffe_pkg::result_t                result
);

  localparam int AVG_BITS  = ffe_pkg::AVG_BITS;
  localparam int FRAC      = ffe_pkg::FRACTION_BITS;
  localparam int GB        = ffe_pkg::GAIN_BITS;
  localparam int EW_BITS   = AVG_BITS + ffe_pkg::GAIN_REG_BITS;
  localparam int LIM_BITS  = AVG_BITS + ffe_pkg::FACTOR_BITS;
  localparam int DIST_BITS = LIM_BITS - GB;

  function automatic logic [AVG_BITS-1:0] ewma(
    input logic [AVG_BITS-1:0]               old_v,
    input logic [AVG_BITS-1:0]               spot,
    input logic [ffe_pkg::GAIN_REG_BITS-1:0] gain
  );
    logic [ffe_pkg::GAIN_REG_BITS-1:0] g;
    logic [ffe_pkg::GAIN_REG_BITS-1:0] w;
    logic                              up;
    logic [AVG_BITS-1:0]               d;
    logic [EW_BITS-1:0]                p;
    logic [AVG_BITS-1:0]               r;
    g  = gain[GB] ? {1'b1, {GB{1'b0}}} : gain;
    w  = {1'b1, {GB{1'b0}}} - g;
    up = spot >= old_v;
    d  = up ? spot - old_v : old_v - spot;
    p  = EW_BITS'(d) * EW_BITS'(w) + (EW_BITS'(1) << (GB - 1));
    r  = p[GB +: AVG_BITS];
    return up ? old_v + r : old_v - r;
  endfunction

  logic [AVG_BITS-1:0]             stable_avg, agile_avg, center_avg, range_avg;
  logic [ffe_pkg::SAMPLE_BITS-1:0] previous_sample;
  logic                            control_lost, seeded;

  logic [AVG_BITS-1:0]             stable_old, agile_old, center_old, range_old;
  logic [ffe_pkg::SAMPLE_BITS-1:0] prev_old;
  logic                            lost_old, seeded_old;

  logic [AVG_BITS-1:0]             stable_next, agile_next, center_next, range_next;
  logic                            lost_next;

  logic [AVG_BITS-1:0]             s_fx, mr_fx;
  logic [ffe_pkg::SAMPLE_BITS-1:0] mr;
  logic [LIM_BITS-1:0]             lim_prod;
  logic [DIST_BITS-1:0]            lim_dist;
  logic [DIST_BITS:0]              upper;
  logic [DIST_BITS-1:0]            lower;
  logic                            in_limits;
  logic [AVG_BITS-1:0]             agile_ew, stable_ew, center_ew, range_ew;
  logic [AVG_BITS-1:0]             sel;
  logic [AVG_BITS:0]               rounded;

  // restart clears the state seen by this beat
  assign stable_old = mode ? '0 : stable_avg;
  assign agile_old  = mode ? '0 : agile_avg;
  assign center_old = mode ? '0 : center_avg;
  assign range_old  = mode ? '0 : range_avg;
  assign prev_old   = mode ? '0 : previous_sample;
  assign lost_old   = mode ? 1'b0 : control_lost;
  assign seeded_old = mode ? 1'b0 : seeded;

  assign s_fx  = {sample, {FRAC{1'b0}}};
  assign mr    = (sample >= prev_old) ? sample - prev_old : prev_old - sample;
  assign mr_fx = {mr, {FRAC{1'b0}}};

  // control limits from the old center and range
  assign lim_prod  = LIM_BITS'(range_old) * LIM_BITS'(cfg.limit_factor)
                     + (LIM_BITS'(1) << (GB - 1));
  assign lim_dist  = lim_prod[LIM_BITS-1:GB];
  assign upper     = (DIST_BITS + 1)'(center_old) + (DIST_BITS + 1)'(lim_dist);
  assign lower     = (lim_dist > DIST_BITS'(center_old)) ? '0
                     : DIST_BITS'(center_old) - lim_dist;
  assign in_limits = (DIST_BITS'(s_fx) >= lower) && ((DIST_BITS + 1)'(s_fx) <= upper);

  assign agile_ew  = ewma(agile_old, s_fx, cfg.fast_gain);
  assign stable_ew = ewma(stable_old, s_fx, cfg.slow_gain);
  assign center_ew = ewma(center_old, s_fx, cfg.center_gain);
  assign range_ew  = ewma(range_old, mr_fx, cfg.range_gain);

  always_comb begin
    if (!seeded_old) begin
      agile_next  = s_fx;
      stable_next = s_fx;
      center_next = s_fx;
      range_next  = range_old;
      lost_next   = lost_old;
    end else begin
      agile_next  = agile_ew;
      stable_next = stable_ew;
      center_next = center_ew;
      range_next  = (in_limits || range_old == '0) ? range_ew : range_old;
      lost_next   = !in_limits;
    end
  end

  // rounded and saturated estimate
  assign sel     = lost_next ? stable_next : agile_next;
  assign rounded = (AVG_BITS + 1)'(sel) + ((AVG_BITS + 1)'(1) << (FRAC - 1));
  assign result.estimate = rounded[AVG_BITS] ? '1 : rounded[FRAC +: ffe_pkg::SAMPLE_BITS];
  assign result.alarm    = lost_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_avg      <= '0;
      agile_avg       <= '0;
      center_avg      <= '0;
      range_avg       <= '0;
      previous_sample <= '0;
      control_lost    <= 1'b0;
      seeded          <= 1'b0;
    end else if (advance) begin
      stable_avg      <= stable_next;
      agile_avg       <= agile_next;
      center_avg      <= center_next;
      range_avg       <= range_next;
      previous_sample <= sample;
      control_lost    <= lost_next;
      seeded          <= 1'b1;
    end
  end

endmodule

FILE: hdl/flip_flop_estimator_top.sv
// flip-flop estimator top: input register, update core, result register, apb registers
// path: an accepted sample beat is held in the input register, its result beat in the result register
// throughput: one beat per cycle while result_ch.ready does not stall the output, set by the state update in ffe_core
// reset: synchronous rst clears all averages, flags and valids and restores register defaults
// depends on ffe_pkg, ffe_sample_if, ffe_result_if, ffe_cfg_regs, ffe_core
module flip_flop_estimator_top (
  input  logic                          clk,
  input  logic                          rst,
  ffe_sample_if.sink                    sample_ch,
  ffe_result_if.source                  result_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffe_pkg::ADDR_BITS-1:0] paddr,
  input  logic [ffe_pkg::DATA_BITS-1:0] pwdata,
  output logic [ffe_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  ffe_pkg::cfg_t                   cfg;
  ffe_pkg::result_t                result;
  logic                            in_valid;
  logic [ffe_pkg::SAMPLE_BITS-1:0] in_sample;
  logic                            in_mode;
  logic                            out_valid;
  ffe_pkg::result_t                out_data;
  logic                            advance;

  ffe_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffe_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .sample  (in_sample),
    .mode    (in_mode),
    .result  (result)
  );

  assign advance         = in_valid && (!out_valid || result_ch.ready);
  assign sample_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample_ch.ready) begin
      in_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ch.valid && sample_ch.ready) begin
      in_sample <= sample_ch.sample;
      in_mode   <= sample_ch.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign result_ch.valid    = out_valid;
  assign result_ch.estimate = out_data.estimate;
  assign result_ch.alarm    = out_data.alarm;

endmodule
